// ----- rtl/ihb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the IPv4 header builder.
// No dependencies; used by every module of the block.
package ihb_pkg;

  // Header layout
  localparam int unsigned HDR_BYTES  = 20;
  localparam int unsigned HDR_CNT_W  = $clog2(HDR_BYTES);
  localparam int unsigned HDR_WORDS  = HDR_BYTES / 2;
  localparam logic [3:0]  IP_VERSION = 4'd4;
  localparam logic [3:0]  IP_IHL     = 4'd5;
  localparam logic [15:0] LEN_MAX    = 16'hffff;

  // Words of the header, in wire order
  localparam logic [3:0] W_VER_TOS   = 4'd0;
  localparam logic [3:0] W_TOT_LEN   = 4'd1;
  localparam logic [3:0] W_IDENT     = 4'd2;
  localparam logic [3:0] W_FRAG      = 4'd3;
  localparam logic [3:0] W_TTL_PROTO = 4'd4;
  localparam logic [3:0] W_CHECKSUM  = 4'd5;
  localparam logic [3:0] W_SRC_HI    = 4'd6;
  localparam logic [3:0] W_SRC_LO    = 4'd7;
  localparam logic [3:0] W_DST_HI    = 4'd8;
  localparam logic [3:0] W_DST_LO    = 4'd9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_TYPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_ID      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAG_FLAG_BITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAG_POSITION  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = 3'd5;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_SERVICE_TYPE   = 8'd0;
  localparam logic [15:0] RST_PACKET_ID      = 16'hca9f;
  localparam logic [2:0]  RST_FRAG_FLAG_BITS = 3'd2;
  localparam logic [12:0] RST_FRAG_POSITION  = 13'd0;
  localparam logic [7:0]  RST_HOP_LIMIT      = 8'd64;
  localparam logic [31:0] RST_SOURCE_ADDRESS = 32'd0;

  // Item kinds
  localparam logic FUNC_HEADER  = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0]  service_type;
    logic [15:0] packet_id;
    logic [2:0]  frag_flag_bits;
    logic [12:0] frag_position;
    logic [7:0]  hop_limit;
    logic [31:0] source_address;
  } cfg_t;

  // One classified item as it sits in the queue
  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic        data_last;
    logic [15:0] total_len;
    logic [7:0]  proto_number;
    logic [31:0] dest_address;
  } entry_t;

endpackage

// ----- rtl/ihb_front.sv -----
`timescale 1ns / 1ps
// Front end: takes input beats, works out the saturated total length and
// packs the item for the queue. Depends on ihb_pkg.
module ihb_front (
  input  logic                func_i,
  input  logic [15:0]         data_length_i,
  input  logic [7:0]          proto_number_i,
  input  logic [31:0]         dest_address_i,
  input  logic [7:0]          data_byte_i,
  input  logic                data_last_i,
  output ihb_pkg::entry_t     entry_o
);

  logic [16:0] len_sum;
  logic [15:0] total_len;

  // Total length = payload + header, clamped to 16 bits
  assign len_sum   = {1'b0, data_length_i} + 17'(ihb_pkg::HDR_BYTES);
  assign total_len = len_sum[16] ? ihb_pkg::LEN_MAX : len_sum[15:0];

  always_comb begin
    entry_o.func         = func_i;
    entry_o.data_byte    = data_byte_i;
    entry_o.data_last    = data_last_i;
    entry_o.total_len    = total_len;
    entry_o.proto_number = proto_number_i;
    entry_o.dest_address = dest_address_i;
  end

endmodule

// ----- rtl/ihb_queue.sv -----
`timescale 1ns / 1ps
// Short queue of classified items between the front and back ends.
// Depends on ihb_pkg.
module ihb_queue #(
  parameter int unsigned DEPTH = ihb_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  ihb_pkg::entry_t wr_entry_i,
  output logic            full_o,
  input  logic            rd_i,
  output ihb_pkg::entry_t rd_entry_o,
  output logic            empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ihb_pkg::entry_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && !empty_o;
  assign rd_entry_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

// ----- rtl/ihb_back.sv -----
`timescale 1ns / 1ps
// Back end: serialises a header request into 20 bytes with a running
// ones'-complement checksum, or passes a payload byte. Depends on ihb_pkg.
module ihb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ihb_pkg::cfg_t   cfg_i,
  input  ihb_pkg::entry_t entry_i,
  input  logic            entry_valid_i,
  output logic            entry_pop_o,
  output logic [7:0]      out_byte_o,
  output logic            out_kind_o,
  output logic            out_last_o,
  output logic            empty_o,
  input  logic            pop_i
);

  localparam logic [ihb_pkg::HDR_CNT_W-1:0] LAST_CNT =
    ihb_pkg::HDR_CNT_W'(ihb_pkg::HDR_BYTES - 1);
  localparam logic [ihb_pkg::HDR_CNT_W-1:0] SUM_CNT =
    ihb_pkg::HDR_CNT_W'(ihb_pkg::HDR_WORDS);

  // Header word at a given index, checksum word supplied by the caller
  function automatic logic [15:0] hdr_word(
    input logic [3:0]      idx,
    input ihb_pkg::entry_t e,
    input ihb_pkg::cfg_t   c,
    input logic [15:0]     csum
  );
    logic [15:0] w;
    case (idx)
      ihb_pkg::W_VER_TOS:   w = {ihb_pkg::IP_VERSION, ihb_pkg::IP_IHL, c.service_type};
      ihb_pkg::W_TOT_LEN:   w = e.total_len;
      ihb_pkg::W_IDENT:     w = c.packet_id;
      ihb_pkg::W_FRAG:      w = {c.frag_flag_bits, c.frag_position};
      ihb_pkg::W_TTL_PROTO: w = {c.hop_limit, e.proto_number};
      ihb_pkg::W_CHECKSUM:  w = csum;
      ihb_pkg::W_SRC_HI:    w = c.source_address[31:16];
      ihb_pkg::W_SRC_LO:    w = c.source_address[15:0];
      ihb_pkg::W_DST_HI:    w = e.dest_address[31:16];
      ihb_pkg::W_DST_LO:    w = e.dest_address[15:0];
      default:              w = 16'h0000;
    endcase
    return w;
  endfunction

  logic [ihb_pkg::HDR_CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_kind_q, out_kind_d;
  logic        out_last_q, out_last_d;

  logic        advance;
  logic [15:0] add_word;
  logic [16:0] add_sum;
  logic [15:0] byte_word;
  logic [7:0]  hdr_byte;

  // Entry waiting and output register free, or emptied this cycle
  assign advance = entry_valid_i && (!out_valid_q || pop_i);

  // End-around carry add of the next header word
  assign add_word = hdr_word(cnt_q[3:0], entry_i, cfg_i, 16'h0000);
  assign add_sum  = {1'b0, acc_q} + {1'b0, add_word};

  // Byte of the header at the current position
  assign byte_word = hdr_word(cnt_q[ihb_pkg::HDR_CNT_W-1:1], entry_i, cfg_i, ~acc_q);
  assign hdr_byte  = cnt_q[0] ? byte_word[7:0] : byte_word[15:8];

  always_comb begin
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !pop_i;
    out_byte_d  = out_byte_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    entry_pop_o = 1'b0;
    if (advance) begin
      out_valid_d = 1'b1;
      if (entry_i.func == ihb_pkg::FUNC_PAYLOAD) begin
        out_byte_d  = entry_i.data_byte;
        out_kind_d  = ihb_pkg::KIND_PAYLOAD;
        out_last_d  = entry_i.data_last;
        entry_pop_o = 1'b1;
      end else begin
        out_byte_d = hdr_byte;
        out_kind_d = ihb_pkg::KIND_HEADER;
        out_last_d = (cnt_q == LAST_CNT);
        if (cnt_q < SUM_CNT) begin
          acc_d = add_sum[15:0] + {15'd0, add_sum[16]};
        end
        if (cnt_q == LAST_CNT) begin
          cnt_d       = '0;
          acc_d       = '0;
          entry_pop_o = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign out_byte_o = out_byte_q;
  assign out_kind_o = out_kind_q;
  assign out_last_o = out_last_q;
  assign empty_o    = !out_valid_q;

endmodule

// ----- rtl/ipv4_header_builder_checksum_top.sv -----
`timescale 1ns / 1ps
// Top level of the IPv4 header builder: configuration registers, front end,
// item queue and back end. Depends on ihb_pkg, ihb_front, ihb_queue, ihb_back.

// Builds a 20-byte IPv4 header (no options) on request and passes payload
// bytes through, on a queue-style interface at both ends. A payload beat
// gives one result beat and the block sustains one per clock while results
// are popped; a header request gives 20 result beats from the byte-wide
// serialiser in the back end, which also folds the header checksum one
// 16-bit word per header byte during the first ten. A queue of QUEUE_DEPTH
// items between the front and back ends keeps taking input beats while a
// header is being sent, until it is full. Total length is payload length
// plus 20, clamped at 65535. Configuration registers take a write whenever
// cfg_we_i is high; writes to indexes past the last register are dropped.
module ipv4_header_builder_checksum_top #(
  parameter int unsigned QUEUE_DEPTH = ihb_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration
  input  logic                           cfg_we_i,
  input  logic [ihb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ihb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input beats
  input  logic                           push,
  output logic                           full,
  input  logic                           func_i,
  input  logic [15:0]                    data_length_i,
  input  logic [7:0]                     proto_number_i,
  input  logic [31:0]                    dest_address_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           data_last_i,
  // Result beats
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte_o,
  output logic                           out_kind_o,
  output logic                           out_last_o
);

  ihb_pkg::cfg_t   cfg_q;
  ihb_pkg::entry_t front_entry;
  ihb_pkg::entry_t head_entry;
  logic            queue_empty;
  logic            head_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.service_type   <= ihb_pkg::RST_SERVICE_TYPE;
      cfg_q.packet_id      <= ihb_pkg::RST_PACKET_ID;
      cfg_q.frag_flag_bits <= ihb_pkg::RST_FRAG_FLAG_BITS;
      cfg_q.frag_position  <= ihb_pkg::RST_FRAG_POSITION;
      cfg_q.hop_limit      <= ihb_pkg::RST_HOP_LIMIT;
      cfg_q.source_address <= ihb_pkg::RST_SOURCE_ADDRESS;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ihb_pkg::REG_SERVICE_TYPE:   cfg_q.service_type   <= cfg_data_i[7:0];
        ihb_pkg::REG_PACKET_ID:      cfg_q.packet_id      <= cfg_data_i[15:0];
        ihb_pkg::REG_FRAG_FLAG_BITS: cfg_q.frag_flag_bits <= cfg_data_i[2:0];
        ihb_pkg::REG_FRAG_POSITION:  cfg_q.frag_position  <= cfg_data_i[12:0];
        ihb_pkg::REG_HOP_LIMIT:      cfg_q.hop_limit      <= cfg_data_i[7:0];
        ihb_pkg::REG_SOURCE_ADDRESS: cfg_q.source_address <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  ihb_front u_front (
    .func_i         (func_i),
    .data_length_i  (data_length_i),
    .proto_number_i (proto_number_i),
    .dest_address_i (dest_address_i),
    .data_byte_i    (data_byte_i),
    .data_last_i    (data_last_i),
    .entry_o        (front_entry)
  );

  ihb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (push),
    .wr_entry_i (front_entry),
    .full_o     (full),
    .rd_i       (head_pop),
    .rd_entry_o (head_entry),
    .empty_o    (queue_empty)
  );

  ihb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .entry_i       (head_entry),
    .entry_valid_i (!queue_empty),
    .entry_pop_o   (head_pop),
    .out_byte_o    (out_byte_o),
    .out_kind_o    (out_kind_o),
    .out_last_o    (out_last_o),
    .empty_o       (empty),
    .pop_i         (pop)
  );

endmodule
